>>> design/wcs_pkg.sv
package wcs_pkg;

	// Event kinds carried on the input tuser field.
	localparam logic [1:0] FUNC_TRIGGER = 2'd0;
	localparam logic [1:0] FUNC_LENGTH  = 2'd1;
	localparam logic [1:0] FUNC_ADVANCE = 2'd2;
	localparam logic [1:0] FUNC_QUERY   = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_DAC_POWER   = 3'd0;
	localparam logic [2:0] REG_LENGTH_ON   = 3'd1;
	localparam logic [2:0] REG_VOLUME_CODE = 3'd2;
	localparam logic [2:0] REG_FREQUENCY   = 3'd3;
	localparam logic [2:0] REG_WAVE_WORD_0 = 3'd4;
	localparam logic [2:0] REG_WAVE_WORD_1 = 3'd5;
	localparam logic [2:0] REG_WAVE_WORD_2 = 3'd6;
	localparam logic [2:0] REG_WAVE_WORD_3 = 3'd7;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int WAVE_WORDS  = 4;

	localparam logic [11:0] PERIOD_BASE     = 12'd2048;
	localparam logic [8:0]  LENGTH_FULL     = 9'd256;
	localparam logic [8:0]  LENGTH_SHORT    = 9'd255;

	typedef struct packed {
		logic [8:0]  length_left;
		logic [12:0] period_out;
		logic        channel_active;
		logic [3:0]  sample_out;
	} result_t;

	// Right shift applied to the nibble for each volume code; a shift of four mutes.
	function automatic logic [2:0] vol_shift(input logic [1:0] code);
		logic [2:0] sh;
		begin
			case (code)
				2'd0: sh = 3'd4;
				2'd1: sh = 3'd0;
				2'd2: sh = 3'd1;
				2'd3: sh = 3'd2;
				default: sh = 3'd4;
			endcase
			return sh;
		end
	endfunction

endpackage

>>> design/wave_channel_sequencer_top.sv
// Wave-table sound channel sequencer.
// Input channel (s_axis_*): one beat is one event. tuser carries the event kind
// (trigger, length clock, position advance, query) and tdata bit 0 tells a
// trigger that the next frame-sequencer step does not clock length.
// Output channel (m_axis_*): exactly one result beat per input beat, in order,
// holding the shifted sample nibble, the channel enable, the timer period and
// the remaining length count.
// Configuration port (cfg_we/cfg_index/cfg_data): registers are written on any
// clock edge with cfg_we high; write them only while no event is in flight.
// Results: the result of an accepted event is written into the output
// register at the accepting edge, or into the skid register during a stall.
// Throughput: one event per clock unless stalled. The channel state is
// updated at the accepting edge, so events may arrive back to back.
// Stall: an output register and a one-beat skid register hold results; when
// both are full, s_axis_tready drops until the receiver takes a beat.
// Reset (arst_n low): all configuration and channel state clear to zero and
// both result registers empty, so s_axis_tready is high.
module wave_channel_sequencer_top import wcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Event input.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] next_step_not_length, [7:1] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] func
	// Result output.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [3:0] sample_out, [4] channel_active,
	                                    // [17:5] period_out, [26:18] length_left,
	                                    // [31:27] zero
	// Configuration writes.
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// Configuration registers.
	logic        dac_power_q;
	logic        length_on_q;
	logic [1:0]  volume_code_q;
	logic [10:0] frequency_q;
	logic [31:0] wave_word_q [WAVE_WORDS];

	// Channel state.
	logic        channel_on_q;
	logic [4:0]  wave_position_q;
	logic [7:0]  sample_byte_q;
	logic [8:0]  length_count_q;
	logic [12:0] timer_period_q;

	// Result holding.
	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;

	logic in_accept;
	logic out_take;
	logic [1:0] func;
	logic       not_len;

	// Next-state values.
	logic        channel_on_d;
	logic [4:0]  wave_position_d;
	logic [7:0]  sample_byte_d;
	logic [8:0]  length_count_d;
	logic [12:0] timer_period_d;
	logic [3:0]  nibble;
	logic [4:0]  advance_pos;
	logic [3:0]  wave_idx;
	logic [31:0] wave_sel;
	logic [11:0] period_half;
	result_t     result_d;

	assign s_axis_tready = !skid_valid_q;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign out_take      = out_valid_q && m_axis_tready;
	assign func          = s_axis_tuser;
	assign not_len       = s_axis_tdata[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dac_power_q   <= 1'b0;
			length_on_q   <= 1'b0;
			volume_code_q <= 2'd0;
			frequency_q   <= 11'd0;
			for (int i = 0; i < WAVE_WORDS; i++) begin
				wave_word_q[i] <= 32'd0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DAC_POWER:   dac_power_q    <= cfg_data[0];
				REG_LENGTH_ON:   length_on_q    <= cfg_data[0];
				REG_VOLUME_CODE: volume_code_q  <= cfg_data[1:0];
				REG_FREQUENCY:   frequency_q    <= cfg_data[10:0];
				REG_WAVE_WORD_0: wave_word_q[0] <= cfg_data;
				REG_WAVE_WORD_1: wave_word_q[1] <= cfg_data;
				REG_WAVE_WORD_2: wave_word_q[2] <= cfg_data;
				REG_WAVE_WORD_3: wave_word_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// The byte fetched on an advance is the one under the new position.
	assign advance_pos = wave_position_q + 5'd1;
	assign wave_idx    = advance_pos[4:1];
	assign wave_sel    = wave_word_q[wave_idx[3:2]];
	assign period_half = PERIOD_BASE - {1'b0, frequency_q};

	always_comb begin
		channel_on_d    = channel_on_q;
		wave_position_d = wave_position_q;
		sample_byte_d   = sample_byte_q;
		length_count_d  = length_count_q;
		timer_period_d  = timer_period_q;
		case (func)
			FUNC_TRIGGER: begin
				// The sample byte is kept; only the position restarts.
				channel_on_d    = dac_power_q;
				wave_position_d = 5'd0;
				timer_period_d  = {period_half, 1'b0};
				if (length_count_q == 9'd0) begin
					length_count_d = (length_on_q && not_len) ? LENGTH_SHORT : LENGTH_FULL;
				end
			end
			FUNC_LENGTH: begin
				if (length_on_q && (length_count_q != 9'd0)) begin
					length_count_d = length_count_q - 9'd1;
					if (length_count_q == 9'd1) begin
						channel_on_d = 1'b0;
					end
				end
			end
			FUNC_ADVANCE: begin
				wave_position_d = advance_pos;
			end
			FUNC_QUERY: ;
			default: ;
		endcase
		if (func == FUNC_ADVANCE) begin
			sample_byte_d = wave_sel[{wave_idx[1:0], 3'b000} +: 8];
		end
		// Odd positions play the low nibble, even ones the high nibble.
		nibble = wave_position_d[0] ? sample_byte_d[3:0] : sample_byte_d[7:4];
		result_d.sample_out     = nibble >> vol_shift(volume_code_q);
		result_d.channel_active = channel_on_d;
		result_d.period_out     = timer_period_d;
		result_d.length_left    = length_count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_on_q    <= 1'b0;
			wave_position_q <= 5'd0;
			sample_byte_q   <= 8'd0;
			length_count_q  <= 9'd0;
			timer_period_q  <= 13'd0;
		end else if (in_accept) begin
			channel_on_q    <= channel_on_d;
			wave_position_q <= wave_position_d;
			sample_byte_q   <= sample_byte_d;
			length_count_q  <= length_count_d;
			timer_period_q  <= timer_period_d;
		end
	end

	// Output register with one skid beat behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= in_accept || skid_valid_q || (out_valid_q && !m_axis_tready);
			if (skid_valid_q && out_take) begin
				skid_valid_q <= 1'b0;
			end else if (in_accept && out_valid_q && !m_axis_tready) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (in_accept) begin
			if (!out_valid_q || m_axis_tready) begin
				out_q <= result_d;
			end else begin
				skid_q <= result_d;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_q};

	// A full skid register always has a result in front of it.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid beat held without an output beat");

	// A trigger with the DAC off leaves the channel off.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (func == FUNC_TRIGGER) && !dac_power_q) |=> !channel_on_q)
		else $error("trigger with DAC off enabled the channel");

	// The length count never goes past a full reload.
	assert property (@(posedge clk) disable iff (!arst_n)
		length_count_q <= LENGTH_FULL)
		else $error("length count above full reload");

	// Only a trigger may raise the length count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (func != FUNC_TRIGGER)) |=> (length_count_q <= $past(length_count_q)))
		else $error("length count grew without a trigger");

	// A beat stalled at the output holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

>>> tb/sv/tb_wave_channel_sequencer_top.sv
`timescale 1ns / 1ps

module tb_wave_channel_sequencer_top;
	import wcs_pkg::*;

	// How the two sides of the stream pace themselves during a phase.
	typedef enum int {
		PACE_FULL,
		PACE_SRC_IDLE,
		PACE_SINK_STALL,
		PACE_BOTH
	} pace_e;

	// A row of the directed table is either a register write or one event beat.
	typedef enum logic {
		ROW_CFG,
		ROW_EVENT
	} row_kind_e;

	typedef struct {
		row_kind_e       kind;
		logic [2:0]      index;
		logic [31:0]     value;
		logic [1:0]      func;
		logic            nsl;
		logic            typed;
		result_t         want;
	} stim_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	wave_channel_sequencer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [0] next_step_not_length, [7:1] zero
		.s_axis_tuser  (s_axis_tuser),   // [1:0] func
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [3:0] sample_out, [4] channel_active,
		                                 // [17:5] period_out, [26:18] length_left
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Shadow copy of the configuration registers, updated at each write.
	logic        dac_on;
	logic        len_enable;
	logic [1:0]  volume_sel;
	logic [10:0] freq_val;
	logic [31:0] wave_words [WAVE_WORDS];

	// Shadow copy of the channel state.
	logic        chan_on;
	logic [4:0]  wave_pos;
	logic [7:0]  held_byte;
	logic [8:0]  len_count;
	logic [12:0] timer_period;

	// Results predicted for accepted events, oldest first.
	result_t pending_results [$];
	stim_row_t directed_rows [$];
	pace_e pace = PACE_FULL;
	int fail_count = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Applies one event to the shadow channel and returns the beat the block
	// should produce for it.
	function automatic result_t channel_step(logic [1:0] func, logic nsl);
		result_t r;
		logic [3:0] byte_idx;
		logic [3:0] nib;
		case (func)
			FUNC_TRIGGER: begin
				chan_on = 1'b1;
				// A zero count reloads; the short reload applies only when the
				// next sequencer step would not clock length itself.
				if (len_count == '0) begin
					len_count = (len_enable && nsl) ? LENGTH_SHORT : LENGTH_FULL;
				end
				// The position restarts but the held byte is kept as it is.
				wave_pos = '0;
				timer_period = (13'(PERIOD_BASE) - 13'(freq_val)) << 1;
				if (!dac_on) begin
					chan_on = 1'b0;
				end
			end
			FUNC_LENGTH: begin
				if (len_enable && len_count != '0) begin
					len_count = len_count - 9'd1;
					if (len_count == '0) begin
						chan_on = 1'b0;
					end
				end
			end
			FUNC_ADVANCE: begin
				wave_pos = wave_pos + 5'd1;
				byte_idx = wave_pos[4:1];
				held_byte = wave_words[byte_idx[3:2]][byte_idx[1:0]*8 +: 8];
			end
			default: begin
			end
		endcase
		// Odd positions play the low nibble; the nibble is reported even when
		// the channel is off.
		nib = wave_pos[0] ? held_byte[3:0] : held_byte[7:4];
		case (volume_sel)
			2'd0: nib = '0;
			2'd1: nib = nib;
			2'd2: nib = nib >> 1;
			default: nib = nib >> 2;
		endcase
		r.sample_out = nib;
		r.channel_active = chan_on;
		r.period_out = timer_period;
		r.length_left = len_count;
		return r;
	endfunction

	function automatic void add_cfg(logic [2:0] index, logic [31:0] value);
		stim_row_t row;
		row = '{kind: ROW_CFG, default: '0};
		row.kind = ROW_CFG;
		row.index = index;
		row.value = value;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_event(logic [1:0] func, logic nsl, logic typed, result_t want);
		stim_row_t row;
		row = '{kind: ROW_EVENT, default: '0};
		row.kind = ROW_EVENT;
		row.func = func;
		row.nsl = nsl;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endfunction

	// Sends one event beat. The sender may idle first, depending on the pace.
	// The beat is taken at the first edge with tready high, and the expected
	// result is queued right there. A typed row queues its own value instead.
	task automatic send_event(logic [1:0] func, logic nsl, logic typed, result_t want);
		int idle_pct;
		result_t predicted;
		idle_pct = (pace == PACE_SRC_IDLE) ? 88 : (pace == PACE_BOTH) ? 8 : 0;
		if ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= func;
		s_axis_tdata <= {7'd0, nsl};
		do @(posedge clk); while (!s_axis_tready);
		predicted = channel_step(func, nsl);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// Stops sending and waits until every queued result has come back.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Writes one register. The enable is left high so that writes can follow
	// back to back; the caller lowers it after the last one.
	task automatic cfg_write(logic [2:0] index, logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		case (index)
			REG_DAC_POWER:   dac_on = value[0];
			REG_LENGTH_ON:   len_enable = value[0];
			REG_VOLUME_CODE: volume_sel = value[1:0];
			REG_FREQUENCY:   freq_val = value[10:0];
			REG_WAVE_WORD_0: wave_words[0] = value;
			REG_WAVE_WORD_1: wave_words[1] = value;
			REG_WAVE_WORD_2: wave_words[2] = value;
			REG_WAVE_WORD_3: wave_words[3] = value;
			default: begin
			end
		endcase
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// The receiver stalls at random according to the pace of the phase.
	always @(posedge clk) begin
		int stall_pct;
		stall_pct = (pace == PACE_SINK_STALL) ? 88 : (pace == PACE_BOTH) ? 8 : 0;
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Every accepted result beat is matched against the oldest expectation.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = result_t'(m_axis_tdata[26:0]);
			if (pending_results.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result beat, expected none, actual %h",
					$time, m_axis_tdata);
			end else begin
				want = pending_results.pop_front();
				check_field("sample_out", want.sample_out, got.sample_out);
				check_field("channel_active", want.channel_active, got.channel_active);
				check_field("period_out", want.period_out, got.period_out);
				check_field("length_left", want.length_left, got.length_left);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("wave_channel_sequencer_top test failed");
		$finish;
	end

	initial begin
		logic in_cfg;
		logic [1:0] func;
		logic [31:0] freq_pick;
		int pick;
		bit length_heavy;

		// Registers and channel state all start from zero.
		dac_on = 1'b0;
		len_enable = 1'b0;
		volume_sel = '0;
		freq_val = '0;
		for (int w = 0; w < WAVE_WORDS; w++) begin
			wave_words[w] = '0;
		end
		chan_on = 1'b0;
		wave_pos = '0;
		held_byte = '0;
		len_count = '0;
		timer_period = '0;

		// Directed table. Rows whose result follows straight from reset or from
		// extreme settings carry it typed in; the rest rely on the predictor.
		// A query right after reset reports all zeros.
		add_event(FUNC_QUERY, 1'b0, 1'b1, {9'd0, 13'd0, 1'b0, 4'd0});
		// Trigger with the DAC off and length disabled: full reload, period from a
		// zero frequency, channel stays off.
		add_event(FUNC_TRIGGER, 1'b1, 1'b1, {9'd256, 13'd4096, 1'b0, 4'd0});
		// Length clock while length is disabled changes nothing.
		add_event(FUNC_LENGTH, 1'b0, 1'b1, {9'd256, 13'd4096, 1'b0, 4'd0});
		// Mostly all-ones data checks that each register keeps only its own width.
		add_cfg(REG_DAC_POWER, 32'hFFFF_FFFF);
		add_cfg(REG_LENGTH_ON, 32'hFFFF_FFFF);
		add_cfg(REG_VOLUME_CODE, 32'hFFFF_FFFD);
		add_cfg(REG_FREQUENCY, 32'hFFFF_FFFF);
		add_cfg(REG_WAVE_WORD_0, 32'hF00F_A55A);
		add_cfg(REG_WAVE_WORD_1, 32'h1234_5678);
		add_cfg(REG_WAVE_WORD_2, 32'h89AB_CDEF);
		add_cfg(REG_WAVE_WORD_3, 32'hFFFF_FFFF);
		// Trigger with a nonzero count keeps it; the highest frequency gives the
		// shortest period and the held byte is still the reset value.
		add_event(FUNC_TRIGGER, 1'b1, 1'b1, {9'd256, 13'd2, 1'b1, 4'd0});
		add_event(FUNC_ADVANCE, 1'b0, 1'b0, '0);
		add_event(FUNC_ADVANCE, 1'b1, 1'b0, '0);
		add_event(FUNC_ADVANCE, 1'b0, 1'b0, '0);
		add_event(FUNC_ADVANCE, 1'b0, 1'b0, '0);
		add_event(FUNC_LENGTH, 1'b1, 1'b0, '0);
		add_event(FUNC_QUERY, 1'b1, 1'b0, '0);
		// Muted output, then the half and quarter shifts.
		add_cfg(REG_VOLUME_CODE, 32'd0);
		add_event(FUNC_ADVANCE, 1'b0, 1'b0, '0);
		add_cfg(REG_VOLUME_CODE, 32'd2);
		add_event(FUNC_ADVANCE, 1'b0, 1'b0, '0);
		add_cfg(REG_VOLUME_CODE, 32'd3);
		add_event(FUNC_ADVANCE, 1'b1, 1'b0, '0);
		add_event(FUNC_ADVANCE, 1'b0, 1'b0, '0);
		// Lowest frequency, then a trigger with the DAC switched off.
		add_cfg(REG_FREQUENCY, 32'd0);
		add_event(FUNC_TRIGGER, 1'b0, 1'b0, '0);
		add_cfg(REG_DAC_POWER, 32'd0);
		add_event(FUNC_TRIGGER, 1'b1, 1'b0, '0);
		add_event(FUNC_QUERY, 1'b0, 1'b0, '0);

		// Reset is applied once, from the start of the run.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the table. Register writes are grouped; the stream is drained
		// before the first write of each group.
		in_cfg = 1'b0;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				if (!in_cfg) begin
					drain();
					in_cfg = 1'b1;
				end
				cfg_write(directed_rows[i].index, directed_rows[i].value);
			end else begin
				if (in_cfg) begin
					cfg_we <= 1'b0;
					in_cfg = 1'b0;
				end
				send_event(directed_rows[i].func, directed_rows[i].nsl,
					directed_rows[i].typed, directed_rows[i].want);
			end
		end

		// Random phases. Each one reprograms every register while idle, picks a
		// pacing mode, and sends a batch of events. Length is enabled in most
		// phases and every other phase leans on length clocks, so the count runs
		// down to zero and the reload-at-zero cases of trigger get exercised.
		for (int ph = 0; ph < 12; ph++) begin
			drain();
			pace = pace_e'(ph % 4);
			length_heavy = (ph % 2 == 0);
			cfg_write(REG_DAC_POWER, {31'd0, ($urandom_range(9) < 8)});
			cfg_write(REG_LENGTH_ON, {31'd0, ($urandom_range(3) != 0)});
			cfg_write(REG_VOLUME_CODE, $urandom);
			case ($urandom_range(3))
				0: freq_pick = 32'd0;
				1: freq_pick = 32'd2047;
				default: freq_pick = $urandom;
			endcase
			cfg_write(REG_FREQUENCY, freq_pick);
			cfg_write(REG_WAVE_WORD_0, $urandom);
			cfg_write(REG_WAVE_WORD_1, $urandom);
			cfg_write(REG_WAVE_WORD_2, $urandom);
			cfg_write(REG_WAVE_WORD_3, $urandom);
			cfg_we <= 1'b0;
			for (int n = 0; n < 85; n++) begin
				pick = $urandom_range(99);
				if (length_heavy) begin
					func = (pick < 8) ? FUNC_TRIGGER : (pick < 70) ? FUNC_LENGTH :
						(pick < 90) ? FUNC_ADVANCE : FUNC_QUERY;
				end else begin
					func = (pick < 12) ? FUNC_TRIGGER : (pick < 40) ? FUNC_LENGTH :
						(pick < 80) ? FUNC_ADVANCE : FUNC_QUERY;
				end
				send_event(func, 1'($urandom_range(1)), 1'b0, '0);
			end
		end

		// Wait for the last results, then keep the clock running so a stray extra
		// beat would still be caught.
		drain();
		repeat (5) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("wave_channel_sequencer_top test passed");
		end else begin
			$display("wave_channel_sequencer_top test failed");
		end
		$finish;
	end

endmodule
